@@ sv/ida_pkg.sv @@
package ida_pkg;

    // fixed field widths
    localparam int SLOT_W       = 10;
    localparam int STATUS_W     = 2;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;

    // bitmap word geometry
    localparam int WORD_BITS    = 32;
    localparam int WORD_SHIFT   = 5;

    localparam int SLOT_COUNT_DEF = 1024;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOT_USED = 2'd2
    } status_t;

    // request to the word search unit
    typedef struct packed {
        logic                  down;      // search towards bit 0
        logic                  first;     // word holding the pointer: apply bound
        logic [WORD_SHIFT-1:0] start_bit; // pointer bit within that word
    } scan_req_t;

    typedef struct packed {
        logic                  hit;
        logic [WORD_SHIFT-1:0] bit_idx;
    } scan_res_t;

endpackage

@@ sv/inode_id_allocator_unit.sv @@
// Slot allocator: hands out and takes back slot numbers 0..SLOT_COUNT-1 using a
// used-bitmap held in a RAM of 32-bit words, a free count, a next-fit pointer and
// a LIFO of recently freed numbers. An input beat with tuser = 0 allocates, with
// tuser = 1 frees the slot in tdata[9:0]; each input beat gives exactly one output
// beat carrying the slot in tdata[9:0] and the status in tuser (0 ok, 1 no free
// slot, 2 freeing a slot not in use). Allocation pops the LIFO when it holds
// anything; otherwise the bitmap is searched one word at a time (read in
// SCAN_WAIT, then evaluated in the word search unit in SCAN_EVAL), upward from
// the pointer to the top and then downward from just below it. A rejected command
// goes straight to RESULT; a free passes FREE_WAIT and FREE_EVAL, a pop POP_WAIT,
// POP_LOAD, POP_MAP_WAIT and POP_EVAL; a search visits at most NWORDS + 1 words
// (33 at 1024 slots). s_tready is high only while the unit is idle; a finished
// result sits in the output register so the next beat can be taken while it
// waits. After reset the bitmap RAM is cleared one word per cycle, all NWORDS
// words (32 at 1024 slots), with s_tready low throughout.
module inode_id_allocator_unit
    import ida_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [9:0] slot_to_free, [15:10] zero
    input  logic                 s_tuser,   // [0] command

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [9:0] slot, [15:10] zero
    output logic [STATUS_W-1:0]  m_tuser    // [1:0] status
);

    localparam int IW        = $clog2(SLOT_COUNT);        // slot index width
    localparam int CW        = IW + 1;                    // count / depth width
    localparam int XW        = IW + WORD_SHIFT;           // slot widened for word split
    localparam int NWORDS    = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LAST_WORD = NWORDS - 1;

    typedef enum logic [3:0] {
        CLEAR,
        IDLE,
        FREE_WAIT,
        FREE_EVAL,
        POP_WAIT,
        POP_LOAD,
        POP_MAP_WAIT,
        POP_EVAL,
        SCAN_WAIT,
        SCAN_EVAL,
        RESULT
    } state_t;

    state_t               state_reg,      state_next;
    logic [AW-1:0]        word_reg,       word_next;      // map address, also clear counter
    logic [WORD_SHIFT-1:0] bit_reg,       bit_next;
    logic [IW-1:0]        slot_reg,       slot_next;
    logic                 down_reg,       down_next;
    logic                 first_reg,      first_next;
    logic [CW-1:0]        depth_reg,      depth_next;
    logic [CW-1:0]        count_reg,      count_next;
    logic [IW-1:0]        ptr_reg,        ptr_next;
    logic [IW-1:0]        res_slot_reg,   res_slot_next;
    status_t              res_status_reg, res_status_next;
    logic                 m_tvalid_reg,   m_tvalid_next;
    logic [SLOT_W-1:0]    out_slot_reg,   out_slot_next;
    status_t              out_status_reg, out_status_next;

    // bitmap RAM
    logic                 map_we;
    logic [WORD_BITS-1:0] map_wdata;
    logic [WORD_BITS-1:0] map_rdata;

    // freed-slot LIFO RAM
    logic                 stk_we;
    logic [IW-1:0]        stk_rdata;

    // slot -> word / bit splits
    logic [IW-1:0]        in_slot;
    logic [XW-1:0]        in_ext;
    logic [XW-1:0]        ptr_ext;
    logic [XW-1:0]        pop_ext;
    logic [AW-1:0]        ptr_word;
    logic [AW+WORD_SHIFT-1:0] hit_full;

    scan_req_t            scan_req;
    scan_res_t            scan_res;

    logic [WORD_SHIFT-1:0] wbit;
    logic [WORD_BITS-1:0]  wbit_mask;
    logic                  in_range;

    assign in_slot  = IW'(s_tdata[SLOT_W-1:0]);
    assign in_range = 32'(s_tdata[SLOT_W-1:0]) < SLOT_COUNT;
    assign in_ext   = XW'(in_slot);
    assign ptr_ext  = XW'(ptr_reg);
    assign pop_ext  = XW'(stk_rdata);
    assign ptr_word = ptr_ext[WORD_SHIFT +: AW];
    assign hit_full = {word_reg, scan_res.bit_idx};

    assign scan_req.down      = down_reg;
    assign scan_req.first     = first_reg;
    assign scan_req.start_bit = ptr_ext[WORD_SHIFT-1:0];

    assign wbit      = (state_reg == SCAN_EVAL) ? scan_res.bit_idx : bit_reg;
    assign wbit_mask = WORD_BITS'(1) << wbit;

    ida_ram #(
        .WIDTH  (WORD_BITS),
        .DEPTH  (NWORDS),
        .ADDR_W (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (word_reg),
        .wdata (map_wdata),
        .raddr (word_reg),
        .rdata (map_rdata)
    );

    // push writes at depth, pop reads at depth after the decrement
    ida_ram #(
        .WIDTH  (IW),
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (IW)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (depth_reg[IW-1:0]),
        .wdata (slot_reg),
        .raddr (depth_reg[IW-1:0]),
        .rdata (stk_rdata)
    );

    ida_scan #(
        .SLOT_COUNT (SLOT_COUNT),
        .NWORDS     (NWORDS),
        .AW         (AW)
    ) u_scan (
        .word_data (map_rdata),
        .word_idx  (word_reg),
        .req       (scan_req),
        .res       (scan_res)
    );

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        slot_next       = slot_reg;
        down_next       = down_reg;
        first_next      = first_reg;
        depth_next      = depth_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        map_we          = 1'b0;
        map_wdata       = map_rdata | wbit_mask;
        stk_we          = 1'b0;

        unique case (state_reg)
            CLEAR:
            begin
                map_we    = 1'b1;
                map_wdata = '0;
                if (word_reg == AW'(LAST_WORD))
                begin
                    word_next  = '0;
                    state_next = IDLE;
                end
                else
                begin
                    word_next = word_reg + AW'(1);
                end
            end

            IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_FREE)
                    begin
                        if (!in_range)
                        begin
                            res_slot_next   = '0;
                            res_status_next = ST_NOT_USED;
                            state_next      = RESULT;
                        end
                        else
                        begin
                            slot_next  = in_slot;
                            word_next  = in_ext[WORD_SHIFT +: AW];
                            bit_next   = in_ext[WORD_SHIFT-1:0];
                            state_next = FREE_WAIT;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_slot_next   = '0;
                        res_status_next = ST_FULL;
                        state_next      = RESULT;
                    end
                    else if (depth_reg != '0)
                    begin
                        depth_next = depth_reg - CW'(1);
                        state_next = POP_WAIT;
                    end
                    else
                    begin
                        word_next  = ptr_word;
                        first_next = 1'b1;
                        down_next  = 1'b0;
                        state_next = SCAN_WAIT;
                    end
                end
            end

            FREE_WAIT:
            begin
                state_next = FREE_EVAL;
            end

            FREE_EVAL:
            begin
                if (!map_rdata[bit_reg])
                begin
                    res_slot_next   = '0;
                    res_status_next = ST_NOT_USED;
                end
                else
                begin
                    map_we    = 1'b1;
                    map_wdata = map_rdata & ~wbit_mask;
                    if (depth_reg < CW'(SLOT_COUNT))
                    begin
                        stk_we     = 1'b1;
                        depth_next = depth_reg + CW'(1);
                    end
                    if (count_reg < CW'(SLOT_COUNT))
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    ptr_next        = slot_reg;
                    res_slot_next   = slot_reg;
                    res_status_next = ST_OK;
                end
                state_next = RESULT;
            end

            POP_WAIT:
            begin
                state_next = POP_LOAD;
            end

            POP_LOAD:
            begin
                slot_next  = stk_rdata;
                word_next  = pop_ext[WORD_SHIFT +: AW];
                bit_next   = pop_ext[WORD_SHIFT-1:0];
                state_next = POP_MAP_WAIT;
            end

            POP_MAP_WAIT:
            begin
                state_next = POP_EVAL;
            end

            POP_EVAL:
            begin
                // popped slot is taken; pointer stays put
                map_we          = 1'b1;
                count_next      = count_reg - CW'(1);
                res_slot_next   = slot_reg;
                res_status_next = ST_OK;
                state_next      = RESULT;
            end

            SCAN_WAIT:
            begin
                state_next = SCAN_EVAL;
            end

            SCAN_EVAL:
            begin
                if (scan_res.hit)
                begin
                    map_we          = 1'b1;
                    ptr_next        = hit_full[IW-1:0];
                    count_next      = count_reg - CW'(1);
                    res_slot_next   = hit_full[IW-1:0];
                    res_status_next = ST_OK;
                    state_next      = RESULT;
                end
                else if (!down_reg)
                begin
                    if (word_reg == AW'(LAST_WORD))
                    begin
                        // top reached: restart below the pointer going down
                        word_next = ptr_word;
                        down_next = 1'b1;
                        first_next = 1'b1;
                    end
                    else
                    begin
                        word_next  = word_reg + AW'(1);
                        first_next = 1'b0;
                    end
                    state_next = SCAN_WAIT;
                end
                else if (word_reg == '0)
                begin
                    // count said free but nothing found
                    res_slot_next   = '0;
                    res_status_next = ST_FULL;
                    state_next      = RESULT;
                end
                else
                begin
                    word_next  = word_reg - AW'(1);
                    first_next = 1'b0;
                    state_next = SCAN_WAIT;
                end
            end

            RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = IDLE;
                end
            end
        endcase
    end

    // output register: loaded when the result leaves RESULT
    always_comb
    begin
        m_tvalid_next   = m_tvalid_reg;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;
        if (state_reg == RESULT && (!m_tvalid_reg || m_tready))
        begin
            m_tvalid_next   = 1'b1;
            out_slot_next   = SLOT_W'(res_slot_reg);
            out_status_next = res_status_reg;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= CLEAR;
            word_reg       <= '0;
            bit_reg        <= '0;
            slot_reg       <= '0;
            down_reg       <= 1'b0;
            first_reg      <= 1'b0;
            depth_reg      <= '0;
            count_reg      <= CW'(SLOT_COUNT);
            ptr_reg        <= '0;
            res_slot_reg   <= '0;
            res_status_reg <= ST_OK;
            m_tvalid_reg   <= 1'b0;
            out_slot_reg   <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            word_reg       <= word_next;
            bit_reg        <= bit_next;
            slot_reg       <= slot_next;
            down_reg       <= down_next;
            first_reg      <= first_next;
            depth_reg      <= depth_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            res_slot_reg   <= res_slot_next;
            res_status_reg <= res_status_next;
            m_tvalid_reg   <= m_tvalid_next;
            out_slot_reg   <= out_slot_next;
            out_status_reg <= out_status_next;
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(out_slot_reg);
    assign m_tuser  = out_status_reg;

endmodule

@@ sv/ida_ram.sv @@
module ida_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/ida_scan.sv @@
module ida_scan
    import ida_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int NWORDS     = (SLOT_COUNT + WORD_BITS - 1) / WORD_BITS,
    parameter int AW         = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
    input  logic [WORD_BITS-1:0] word_data,
    input  logic [AW-1:0]        word_idx,
    input  scan_req_t            req,
    output scan_res_t            res
);

    localparam int LAST_WORD = NWORDS - 1;
    localparam int LAST_BITS = SLOT_COUNT - LAST_WORD * WORD_BITS;
    localparam logic [WORD_BITS-1:0] LAST_MASK =
        WORD_BITS'((64'd1 << LAST_BITS) - 64'd1);

    logic [WORD_BITS-1:0] valid_mask;
    logic [WORD_BITS-1:0] ge_mask;
    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] free_bits;

    // bits past the last slot never count as free
    assign valid_mask = (word_idx == AW'(LAST_WORD)) ? LAST_MASK : {WORD_BITS{1'b1}};
    assign ge_mask    = {WORD_BITS{1'b1}} << req.start_bit;

    always_comb
    begin
        if (!req.first)
        begin
            range_mask = {WORD_BITS{1'b1}};
        end
        else if (req.down)
        begin
            range_mask = ~ge_mask;
        end
        else
        begin
            range_mask = ge_mask;
        end
    end

    assign free_bits = ~word_data & valid_mask & range_mask;

    // lowest free bit going up, highest going down
    always_comb
    begin
        res.hit     = |free_bits;
        res.bit_idx = '0;
        if (req.down)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                if (free_bits[i])
                begin
                    res.bit_idx = WORD_SHIFT'(i);
                end
            end
        end
        else
        begin
            for (int i = WORD_BITS - 1; i >= 0; i--)
            begin
                if (free_bits[i])
                begin
                    res.bit_idx = WORD_SHIFT'(i);
                end
            end
        end
    end

endmodule
